>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/dmc_pkg.sv
package dmc_pkg;

   localparam int CW         = 17;
   localparam int SW         = 18;
   localparam int PW         = 12;
   localparam int TW         = 16;
   localparam int DIV_NW     = 34;
   localparam int DIV_DW     = 19;
   localparam int TREE_NODES = 65280;
   localparam int TREE_SIZE  = 255;
   localparam int TREE_INNER = 127;
   localparam int THRESH_CAP = 8192;
   localparam int INIT_LOW   = 512;
   localparam int INIT_HIGH  = 2048;
   localparam int TH_RESET   = 256;
   localparam int TH_SPLIT   = 1024;

   typedef enum logic {
      OP_CODE    = 1'b0,
      OP_REBUILD = 1'b1
   } op_type;

   typedef enum logic [13:0] {
      S_SWEEP = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_CUR   = 14'b00000000000100,
      S_RDNXT = 14'b00000000001000,
      S_NXT   = 14'b00000000010000,
      S_D0GO  = 14'b00000000100000,
      S_D0WT  = 14'b00000001000000,
      S_D1GO  = 14'b00000010000000,
      S_D1WT  = 14'b00000100000000,
      S_WR1   = 14'b00001000000000,
      S_WR2   = 14'b00010000000000,
      S_PGO   = 14'b00100000000000,
      S_PWT   = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   // 1.0 = 1024; age by 63/64 and add one unit for the coded bit
   function automatic logic [CW-1:0] age_count(input logic [CW-1:0] x, input logic inc);
      logic [CW+5:0] x63;
      logic [CW-1:0] res;
      x63 = {x, 6'b0} - {6'b0, x};
      res = x63[CW+5:6] + {6'b0, inc, 10'b0};
      return res;
   endfunction

endpackage

>>> hdl/dmc_chan_if.sv
interface dmc_req_if;
   logic valid;
   logic ready;
   logic op;
   logic bit_req;
   modport source (output valid, output op, output bit_req, input ready);
   modport sink (input valid, input op, input bit_req, output ready);
endinterface

interface dmc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] prob_one;
   logic        graph_full;
   modport source (output valid, output prob_one, output graph_full, input ready);
   modport sink (input valid, input prob_one, input graph_full, output ready);
endinterface

>>> hdl/dmc_div.sv
module dmc_div #(
   parameter int NW = 34,
   parameter int DW = 19
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CNTW = $clog2(NW + 1);

   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;

   logic [DW:0]     trial;
   logic [DW+1:0]   diff;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      diff    = {1'b0, trial} - {2'b0, den_ff};
      ge      = ~diff[DW+1];
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
         cnt_in  = CNTW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            // restoring step, one quotient bit per cycle
            rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

endmodule

>>> hdl/dmc_bit_predictor_core.sv
// Dynamic Markov bit model over a node store held in two single-port-write
// memories (counts and links, registered read). After reset, and after every
// rebuild command, a sweep writes the 65280 nodes of the initial tree graph,
// one node a cycle; no request is accepted during the sweep. A coded bit
// reads the current node, writes its aged counts, then reads the successor
// and runs one division for the probability. A clone, when the store has
// room, adds two more divisions and two node writes. A rebuild answers
// after its sweep plus one division. All divisions share one serial divider
// (one quotient bit per cycle). The start threshold register resets to 256
// and is read only at rebuild.
`include "assert_macros.svh"

module dmc_bit_predictor_core #(
   parameter int NODE_COUNT = 131072
) (
   input  logic        clock,
   input  logic        reset,
   dmc_req_if.sink     req_chan,
   dmc_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int LW  = $clog2(NODE_COUNT);
   localparam int NFW = $clog2(NODE_COUNT + 1);
   localparam int CW  = dmc_pkg::CW;
   localparam int SW  = dmc_pkg::SW;
   localparam int NW  = dmc_pkg::DIV_NW;
   localparam int DW  = dmc_pkg::DIV_DW;
   localparam int TW  = dmc_pkg::TW;

   logic [2*CW-1:0] cnt_mem [NODE_COUNT];
   logic [2*LW-1:0] lnk_mem [NODE_COUNT];
   logic [2*CW-1:0] cnt_rd_ff;
   logic [2*LW-1:0] lnk_rd_ff;

   dmc_pkg::state_type state_ff, state_in;
   logic [LW-1:0]  cur_ff, cur_in;
   logic [NFW-1:0] nf_ff, nf_in;
   logic [TW-1:0]  th_ff, th_in;
   logic [31:0]    fine_ff, fine_in;
   logic [31:0]    tally_ff, tally_in;
   logic           init_ff, init_in;
   logic [15:0]    pos_ff, pos_in;
   logic [7:0]     idx_ff, idx_in;
   logic           sweep_rsp_ff, sweep_rsp_in;
   logic           y_ff, y_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [LW-1:0]  cl0_ff, cl0_in, cl1_ff, cl1_in;
   logic [LW-1:0]  nxt_ff, nxt_in;
   logic [CW-1:0]  d0_ff, d0_in, d1_ff, d1_in;
   logic [LW-1:0]  nl0_ff, nl0_in, nl1_ff, nl1_in;
   logic [SW-1:0]  nn_ff, nn_in;
   logic [NW-1:0]  prod0_ff, prod0_in, prod1_ff, prod1_in;
   logic [CW-1:0]  t0_ff, t0_in;
   logic [CW-1:0]  p0_ff, p0_in, p1_ff, p1_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [11:0]    rsp_prob_ff, rsp_prob_in;
   logic           rsp_full_ff, rsp_full_in;
   logic [TW-1:0]  csr_th_ff, csr_th_in;

   logic            cnt_we, lnk_we;
   logic [LW-1:0]   cnt_wa, lnk_wa, rd_addr;
   logic [2*CW-1:0] cnt_wd;
   logic [2*LW-1:0] lnk_wd;

   logic            div_start, div_busy, div_done;
   logic [NW-1:0]   div_dividend, div_quotient;
   logic [DW-1:0]   div_divisor;

   logic            req_fire, slot_free;
   logic [CW-1:0]   c0, c1, cn, rd0, rd1, t1, init_val;
   logic [LW-1:0]   lk0, lk1, rl0, rl1, top;
   logic [SW-1:0]   nn_sum;
   logic [SW:0]     n_plus_th;
   logic            clone, room;
   logic [32:0]     tally_sum;
   logic [15:0]     sw_l0, sw_l1, root;
   logic [6:0]      leaf;

   function automatic logic [LW-1:0] safe_idx(input logic [LW-1:0] v);
      return (NFW'(v) < NFW'(NODE_COUNT)) ? v : '0;
   endfunction

   dmc_div #(.NW(NW), .DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign c0        = cnt_rd_ff[CW-1:0];
   assign c1        = cnt_rd_ff[2*CW-1:CW];
   assign rl0       = lnk_rd_ff[LW-1:0];
   assign rl1       = lnk_rd_ff[2*LW-1:LW];
   assign t1        = div_quotient[CW-1:0];
   assign top       = nf_ff[LW-1:0];
   assign room      = nf_ff < NFW'(NODE_COUNT);
   assign init_val  = init_ff ? CW'(dmc_pkg::INIT_HIGH) : CW'(dmc_pkg::INIT_LOW);
   assign rd_addr   = (state_ff == dmc_pkg::S_RDNXT) ? nxt_ff : cur_ff;

   // initial graph links for the node under the sweep
   always_comb begin
      leaf  = 7'(idx_ff - 8'(dmc_pkg::TREE_INNER));
      root  = {leaf, 9'b0} - {8'b0, leaf, 1'b0};
      if (idx_ff < 8'(dmc_pkg::TREE_INNER)) begin
         sw_l0 = pos_ff + {8'b0, idx_ff} + 16'd1;
         sw_l1 = pos_ff + {8'b0, idx_ff} + 16'd2;
      end else begin
         sw_l0 = root;
         sw_l1 = root + 16'(dmc_pkg::TREE_SIZE);
      end
   end

   always_comb begin
      cn        = y_ff ? c1 : c0;
      lk0       = rl0;
      lk1       = rl1;
      rd0       = c0;
      rd1       = c1;
      nn_sum    = {1'b0, c0} + {1'b0, c1};
      n_plus_th = {2'b0, n_ff} + {3'b0, th_ff};
      clone     = (n_ff > CW'(th_ff)) && ((SW+1)'(nn_sum) > n_plus_th);
      tally_sum = {1'b0, tally_ff} + 33'(nn_sum[SW-1:10]);

      cnt_we = 1'b0;
      cnt_wa = cur_ff;
      cnt_wd = {dmc_pkg::age_count(c1, y_ff), dmc_pkg::age_count(c0, ~y_ff)};
      lnk_we = 1'b0;
      lnk_wa = top;
      lnk_wd = {nl1_ff, nl0_ff};

      div_start    = 1'b0;
      div_dividend = prod0_ff;
      div_divisor  = DW'(nn_ff);

      state_in     = state_ff;
      cur_in       = cur_ff;
      nf_in        = nf_ff;
      th_in        = th_ff;
      fine_in      = fine_ff;
      tally_in     = tally_ff;
      init_in      = init_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      sweep_rsp_in = sweep_rsp_ff;
      y_in         = y_ff;
      n_in         = n_ff;
      cl0_in       = cl0_ff;
      cl1_in       = cl1_ff;
      nxt_in       = nxt_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      nl0_in       = nl0_ff;
      nl1_in       = nl1_ff;
      nn_in        = nn_ff;
      prod0_in     = prod0_ff;
      prod1_in     = prod1_ff;
      t0_in        = t0_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_prob_in  = rsp_prob_ff;
      rsp_full_in  = rsp_full_ff;
      csr_th_in    = csr_wr_en ? csr_wr_data : csr_th_ff;

      unique case (state_ff)
         dmc_pkg::S_SWEEP: begin
            cnt_we = 1'b1;
            cnt_wa = LW'(pos_ff);
            cnt_wd = {init_val, init_val};
            lnk_we = 1'b1;
            lnk_wa = LW'(pos_ff);
            lnk_wd = {LW'(sw_l1), LW'(sw_l0)};
            pos_in = pos_ff + 16'd1;
            idx_in = (idx_ff == 8'(dmc_pkg::TREE_SIZE - 1)) ? 8'd0 : idx_ff + 8'd1;
            if (pos_ff == 16'(dmc_pkg::TREE_NODES - 1)) begin
               p0_in    = init_val;
               p1_in    = init_val;
               state_in = sweep_rsp_ff ? dmc_pkg::S_PGO : dmc_pkg::S_IDLE;
            end
         end
         dmc_pkg::S_IDLE: begin
            if (req_fire) begin
               y_in = req_chan.bit_req;
               if (dmc_pkg::op_type'(req_chan.op) == dmc_pkg::OP_REBUILD) begin
                  init_in      = csr_th_ff < TW'(dmc_pkg::TH_SPLIT);
                  th_in        = csr_th_ff;
                  fine_in      = {5'b0, csr_th_ff, 11'b0};
                  cur_in       = '0;
                  nf_in        = NFW'(dmc_pkg::TREE_NODES);
                  tally_in     = '0;
                  pos_in       = '0;
                  idx_in       = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = dmc_pkg::S_SWEEP;
               end else begin
                  state_in = dmc_pkg::S_CUR;
               end
            end
         end
         dmc_pkg::S_CUR: begin
            // aged counts go back now; the successor address is presented in S_RDNXT
            cnt_we   = 1'b1;
            n_in     = cn;
            cl0_in   = lk0;
            cl1_in   = lk1;
            nxt_in   = safe_idx(y_ff ? lk1 : lk0);
            state_in = dmc_pkg::S_RDNXT;
         end
         dmc_pkg::S_RDNXT: begin
            state_in = dmc_pkg::S_NXT;
         end
         dmc_pkg::S_NXT: begin
            d0_in    = rd0;
            d1_in    = rd1;
            nl0_in   = rl0;
            nl1_in   = rl1;
            nn_in    = nn_sum;
            prod0_in = NW'(rd0 * n_ff);
            prod1_in = NW'(rd1 * n_ff);
            if (clone && room) begin
               state_in = dmc_pkg::S_D0GO;
            end else begin
               if (clone) begin
                  tally_in = tally_sum[32] ? 32'hFFFF_FFFF : tally_sum[31:0];
               end
               cur_in   = nxt_ff;
               p0_in    = rd0;
               p1_in    = rd1;
               state_in = dmc_pkg::S_PGO;
            end
         end
         dmc_pkg::S_D0GO: begin
            div_start = 1'b1;
            state_in  = dmc_pkg::S_D0WT;
         end
         dmc_pkg::S_D0WT: begin
            if (div_done) begin
               t0_in    = div_quotient[CW-1:0];
               state_in = dmc_pkg::S_D1GO;
            end
         end
         dmc_pkg::S_D1GO: begin
            div_start    = 1'b1;
            div_dividend = prod1_ff;
            state_in     = dmc_pkg::S_D1WT;
         end
         dmc_pkg::S_D1WT: begin
            if (div_done) begin
               state_in = dmc_pkg::S_WR1;
            end
         end
         dmc_pkg::S_WR1: begin
            cnt_we   = 1'b1;
            cnt_wa   = top;
            cnt_wd   = {t1, t0_ff};
            lnk_we   = 1'b1;
            state_in = dmc_pkg::S_WR2;
         end
         dmc_pkg::S_WR2: begin
            cnt_we = 1'b1;
            cnt_wa = nxt_ff;
            cnt_wd = {d1_ff - t1, d0_ff - t0_ff};
            lnk_we = 1'b1;
            lnk_wa = cur_ff;
            lnk_wd = y_ff ? {top, cl0_ff} : {cl1_ff, top};
            nf_in  = nf_ff + 1'b1;
            if (th_ff < TW'(dmc_pkg::THRESH_CAP)) begin
               fine_in = fine_ff + 32'd1;
               th_in   = fine_in[26:11];
            end
            cur_in   = top;
            p0_in    = t0_ff;
            p1_in    = t1;
            state_in = dmc_pkg::S_PGO;
         end
         dmc_pkg::S_PGO: begin
            div_start    = 1'b1;
            div_dividend = NW'({p1_ff + 1'b1, 12'b0});
            div_divisor  = DW'(p0_ff) + DW'(p1_ff) + DW'(2);
            state_in     = dmc_pkg::S_PWT;
         end
         dmc_pkg::S_PWT: begin
            if (div_done) begin
               state_in = dmc_pkg::S_OUT;
            end
         end
         dmc_pkg::S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_prob_in  = div_quotient[11:0];
               rsp_full_in  = {7'b0, tally_ff[31:7]} > 32'(NODE_COUNT);
               sweep_rsp_in = 1'b0;
               state_in     = dmc_pkg::S_IDLE;
            end
         end
         default: state_in = dmc_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (lnk_we) begin
         lnk_mem[lnk_wa] <= lnk_wd;
      end
      cnt_rd_ff <= cnt_mem[rd_addr];
      lnk_rd_ff <= lnk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmc_pkg::S_SWEEP;
         cur_ff       <= '0;
         nf_ff        <= NFW'(dmc_pkg::TREE_NODES);
         th_ff        <= TW'(dmc_pkg::TH_RESET);
         fine_ff      <= 32'(dmc_pkg::TH_RESET) << 11;
         tally_ff     <= '0;
         init_ff      <= 1'b1;
         pos_ff       <= '0;
         idx_ff       <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         csr_th_ff    <= TW'(dmc_pkg::TH_RESET);
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         nf_ff        <= nf_in;
         th_ff        <= th_in;
         fine_ff      <= fine_in;
         tally_ff     <= tally_in;
         init_ff      <= init_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         csr_th_ff    <= csr_th_in;
      end
      y_ff        <= y_in;
      n_ff        <= n_in;
      cl0_ff      <= cl0_in;
      cl1_ff      <= cl1_in;
      nxt_ff      <= nxt_in;
      d0_ff       <= d0_in;
      d1_ff       <= d1_in;
      nl0_ff      <= nl0_in;
      nl1_ff      <= nl1_in;
      nn_ff       <= nn_in;
      prod0_ff    <= prod0_in;
      prod1_ff    <= prod1_in;
      t0_ff       <= t0_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign req_chan.ready      = (state_ff == dmc_pkg::S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.prob_one   = rsp_prob_ff;
   assign rsp_chan.graph_full = rsp_full_ff;

   `ASSERT_CLK(a_nf_range, nf_ff <= NFW'(NODE_COUNT), "free node pointer beyond store")
   `ASSERT_CLK(a_div_free, div_start |-> !div_busy, "divider started while busy")
   `ASSERT_CLK(a_req_leaves, req_fire |=> (state_ff != dmc_pkg::S_IDLE), "transfer not taken up")

endmodule
